// File: rtl/core/adip_pkg.sv
// ----------------------------------------------------------------------------
// ASCII decimal integer parser - shared package
// Byte classes, parser phase codes, character codes and the item types that
// pass between the classifying front end and the executing back end.
// ----------------------------------------------------------------------------
package adip_pkg;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Byte classes
	localparam logic [2:0] CL_BLANK = 3'd0;
	localparam logic [2:0] CL_MINUS = 3'd1;
	localparam logic [2:0] CL_DIGIT = 3'd2;
	localparam logic [2:0] CL_END   = 3'd3;
	localparam logic [2:0] CL_OTHER = 3'd4;

	// Parser phases
	localparam logic [1:0] PH_SKIP   = 2'd0;
	localparam logic [1:0] PH_MINUS  = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;

	// Queue depth (two entries keeps one item a cycle with a registered count)
	localparam logic [1:0] QUEUE_FULL = 2'd2;

	// Classified byte
	typedef struct packed {
		logic [2:0] cls;
		logic [3:0] digit;
	} cmd_t;

	// Front-to-back channel
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_chan_t;

	// Result item
	typedef struct packed {
		logic signed [63:0] value;
		logic               overflow;
		logic               no_digits;
		logic               at_end;
	} res_t;

endpackage

// File: rtl/core/ascii_decimal_integer_parser.sv
// Path: an accepted byte that ends a token is written to the front queue; the back
// end takes it when the result queue has room and queues its result there to pop.
// Throughput: one byte per cycle if no queue is full; single acc*10+digit step.
// Both two-entry queues let either side stall without stopping the other.
// Reset (arst_n low, asynchronous): queues empty, parser back to skipping
// blanks with a clear accumulator; payload storage is not cleared.
// ----------------------------------------------------------------------------
// ASCII decimal integer parser - top level
// Byte stream in, one signed 64-bit result per token out, queue handshakes.
// ----------------------------------------------------------------------------
module ascii_decimal_integer_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         in_byte,
	output logic               empty,
	input  logic               pop,
	output logic signed [63:0] value,
	output logic               overflow,
	output logic               no_digits,
	output logic               at_end
);

	adip_pkg::cmd_chan_t cmd_ch;
	logic                cmd_take;

	// Classifying front end
	adip_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.in_byte  (in_byte),
		.full     (full),
		.cmd_ch   (cmd_ch),
		.cmd_take (cmd_take)
	);

	// Executing back end
	adip_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_ch    (cmd_ch),
		.cmd_take  (cmd_take),
		.empty     (empty),
		.pop       (pop),
		.value     (value),
		.overflow  (overflow),
		.no_digits (no_digits),
		.at_end    (at_end)
	);

	// Checks
	a_take_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_ch.valid)
		else $error("back end took an item from an empty queue");

	a_no_digits_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && no_digits) |-> (value == 64'sd0 && !overflow))
		else $error("no-digits item carries a value or overflow");

	a_push_reaches_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !cmd_take) |=> cmd_ch.valid)
		else $error("accepted byte did not reach the front queue");

endmodule

// File: rtl/core/adip_front.sv
// ----------------------------------------------------------------------------
// ASCII decimal integer parser - front end
// Accepts one byte a cycle while its queue is not full, classifies it and
// queues it for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module adip_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [7:0]          in_byte,
	output logic                full,
	output adip_pkg::cmd_chan_t cmd_ch,
	input  logic                cmd_take
);

	adip_pkg::cmd_t cls_cmd;
	adip_pkg::cmd_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;

	// Byte classification
	always_comb begin
		cls_cmd.digit = in_byte[3:0];
		if (in_byte == adip_pkg::CH_NUL) begin
			cls_cmd.cls = adip_pkg::CL_END;
		end else if (in_byte == adip_pkg::CH_SPACE || in_byte == adip_pkg::CH_TAB ||
				in_byte == adip_pkg::CH_LF || in_byte == adip_pkg::CH_CR) begin
			cls_cmd.cls = adip_pkg::CL_BLANK;
		end else if (in_byte == adip_pkg::CH_MINUS) begin
			cls_cmd.cls = adip_pkg::CL_MINUS;
		end else if (in_byte >= adip_pkg::CH_ZERO && in_byte <= adip_pkg::CH_NINE) begin
			cls_cmd.cls = adip_pkg::CL_DIGIT;
		end else begin
			cls_cmd.cls = adip_pkg::CL_OTHER;
		end
	end

	assign full    = (count_q == adip_pkg::QUEUE_FULL);
	assign do_push = push & ~full;

	// Queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cls_cmd;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, cmd_take})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign cmd_ch.valid = (count_q != 2'd0);
	assign cmd_ch.cmd   = mem_q[rd_ptr_q];

endmodule

// File: rtl/core/adip_back.sv
// ----------------------------------------------------------------------------
// ASCII decimal integer parser - back end
// Runs the token state machine on classified bytes, accumulates digits as
// acc*10+digit and queues finished results in a two-entry result queue.
// ----------------------------------------------------------------------------
module adip_back (
	input  logic                clk,
	input  logic                arst_n,
	input  adip_pkg::cmd_chan_t cmd_ch,
	output logic                cmd_take,
	output logic                empty,
	input  logic                pop,
	output logic signed [63:0]  value,
	output logic                overflow,
	output logic                no_digits,
	output logic                at_end
);

	logic [1:0]     phase_q;
	logic           neg_q;
	logic [63:0]    acc_q;
	logic           ovf_q;

	adip_pkg::res_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	logic           is_digit;
	logic           is_end;
	logic [67:0]    mul_sum;
	logic [3:0]     digit;
	logic [1:0]     phase_d;
	logic           neg_d;
	logic [63:0]    acc_d;
	logic           ovf_d;
	logic           emit;
	logic           emit_digits;
	logic           do_pop;
	adip_pkg::res_t res;

	// Take a queued byte whenever the result queue has room
	assign cmd_take = cmd_ch.valid & (count_q != adip_pkg::QUEUE_FULL);
	assign do_pop   = pop & ~empty;
	assign empty    = (count_q == 2'd0);

	assign digit    = cmd_ch.cmd.digit;
	assign is_digit = (cmd_ch.cmd.cls == adip_pkg::CL_DIGIT);
	assign is_end   = (cmd_ch.cmd.cls == adip_pkg::CL_END);

	// acc*10 + digit, carried to 68 bits to catch wrap
	assign mul_sum = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {64'd0, digit};

	// Token state machine
	always_comb begin
		phase_d     = phase_q;
		neg_d       = neg_q;
		acc_d       = acc_q;
		ovf_d       = ovf_q;
		emit        = 1'b0;
		emit_digits = 1'b0;
		case (phase_q)
			adip_pkg::PH_DIGITS: begin
				if (is_digit) begin
					acc_d = mul_sum[63:0];
					ovf_d = ovf_q | (mul_sum[67:64] != 4'd0);
				end else begin
					emit        = 1'b1;
					emit_digits = 1'b1;
				end
			end
			adip_pkg::PH_MINUS: begin
				if (is_digit) begin
					acc_d   = {60'd0, digit};
					phase_d = adip_pkg::PH_DIGITS;
				end else begin
					emit = 1'b1;
				end
			end
			default: begin
				phase_d = adip_pkg::PH_SKIP;
				case (cmd_ch.cmd.cls)
					adip_pkg::CL_BLANK: begin
						phase_d = adip_pkg::PH_SKIP;
					end
					adip_pkg::CL_MINUS: begin
						neg_d   = 1'b1;
						phase_d = adip_pkg::PH_MINUS;
					end
					adip_pkg::CL_DIGIT: begin
						acc_d   = {60'd0, digit};
						phase_d = adip_pkg::PH_DIGITS;
					end
					default: begin
						emit = 1'b1;
					end
				endcase
			end
		endcase
	end

	// Result build: sign, range check against the signed limits
	always_comb begin
		res.at_end    = is_end;
		res.no_digits = ~emit_digits;
		if (emit_digits) begin
			res.value    = neg_q ? (64'd0 - acc_q) : acc_q;
			res.overflow = ovf_q | (neg_q ? (acc_q[63] & (acc_q[62:0] != 63'd0)) : acc_q[63]);
		end else begin
			res.value    = 64'd0;
			res.overflow = 1'b0;
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= adip_pkg::PH_SKIP;
			neg_q   <= 1'b0;
			acc_q   <= 64'd0;
			ovf_q   <= 1'b0;
		end else if (cmd_take) begin
			if (emit) begin
				phase_q <= adip_pkg::PH_SKIP;
				neg_q   <= 1'b0;
				acc_q   <= 64'd0;
				ovf_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				neg_q   <= neg_d;
				acc_q   <= acc_d;
				ovf_q   <= ovf_d;
			end
		end
	end

	// Result queue storage
	always_ff @(posedge clk) begin
		if (cmd_take && emit) begin
			mem_q[wr_ptr_q] <= res;
		end
	end

	// Result queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (cmd_take && emit) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({cmd_take & emit, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign value     = mem_q[rd_ptr_q].value;
	assign overflow  = mem_q[rd_ptr_q].overflow;
	assign no_digits = mem_q[rd_ptr_q].no_digits;
	assign at_end    = mem_q[rd_ptr_q].at_end;

endmodule
